// ===== rtl/mip_pkg.sv =====
// ----------------------------------------------------------------------------
// mip_pkg
// Shared types and constants for the modular inverse block: the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mip_pkg;

    // width of the code width field
    localparam int unsigned CODE_WIDTH_W = 6;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new request
        logic step;   // one bit of the inverse
        logic emit;   // register the result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic eligible;  // odd value and nonzero width
        logic last;      // current step produces the top bit
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/modular_inverse_pow2.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_pow2
// Multiplicative inverse of a value modulo 2^n, with an existence flag.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. For an
// odd value and nonzero code width n (n saturates at MAX_CODE_WIDTH) the
// datapath finds one inverse bit per cycle, between a check state and a
// finish state; an even or zero value, or a zero width, returns inverse 0
// with found clear from the check state. The result is on o_inverse and
// o_found in the one cycle o_valid is high, is held until the next result
// and cannot be held off by the receiver. busy drops together with the
// strobe, so the next request may be taken while a result is being shown.
`default_nettype none

module modular_inverse_pow2 #(
    parameter int unsigned VALUE_WIDTH    = 16,
    parameter int unsigned MAX_CODE_WIDTH = 40
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request side
    input  wire logic                             start,
    output      logic                             busy,
    input  wire logic [VALUE_WIDTH-1:0]           i_value,
    input  wire logic [mip_pkg::CODE_WIDTH_W-1:0] i_code_width,
    // result side
    output      logic                             o_valid,
    output      logic [MAX_CODE_WIDTH-1:0]        o_inverse,
    output      logic                             o_found
);

    // command and status between the sequencer and the bit-serial datapath
    mip_pkg::t_dp_cmd cmd;
    mip_pkg::t_dp_sts sts;

    // sequencer: load, one step per inverse bit, then result register
    mip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // datapath: residual subtract and shift, inverse bits set one at a time
    mip_dp #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_code_width (i_code_width),
        .o_sts        (sts),
        .o_inverse    (o_inverse),
        .o_found      (o_found)
    );

endmodule

`default_nettype wire

// ===== rtl/mip_dp.sv =====
// ----------------------------------------------------------------------------
// mip_dp
// Datapath: bit-serial inverse modulo 2^n, one result bit per step using one
// subtract and a right shift of the running residual.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_dp #(
    parameter int unsigned VALUE_WIDTH    = 16,
    parameter int unsigned MAX_CODE_WIDTH = 40
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mip_pkg::t_dp_cmd                     i_cmd,
    input  wire logic [VALUE_WIDTH-1:0]               i_value,
    input  wire logic [mip_pkg::CODE_WIDTH_W-1:0]     i_code_width,
    output      mip_pkg::t_dp_sts                     o_sts,
    output      logic [MAX_CODE_WIDTH-1:0]            o_inverse,
    output      logic                                 o_found
);

    localparam int unsigned MW = MAX_CODE_WIDTH;
    localparam int unsigned CW = mip_pkg::CODE_WIDTH_W;
    localparam int unsigned IW = $clog2(MW);

    logic [VALUE_WIDTH-1:0] r_v;
    logic [CW-1:0]          r_n;
    logic [MW-1:0]          r_t;
    logic [MW-1:0]          r_x;
    logic [IW-1:0]          r_i;
    logic [MW-1:0]          r_res;
    logic                   r_found;

    logic [CW-1:0]          n_n;
    logic [MW-1:0]          n_t;
    logic [MW-1:0]          sub_t;

    // saturate the requested width
    always_comb begin
        if (i_code_width > CW'(MW)) begin
            n_n = CW'(MW);
        end else begin
            n_n = i_code_width;
        end
    end

    // residual (1 - v*x) / 2^i, kept modulo the remaining width
    assign sub_t = r_t - MW'(r_v);
    assign n_t   = r_t[0] ? (sub_t >> 1) : (r_t >> 1);

    assign o_sts.eligible = r_v[0] && (r_n != '0);
    assign o_sts.last     = (CW'(r_i) == (r_n - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.emit) begin
            r_found <= o_sts.eligible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_value;
            r_n <= n_n;
            r_t <= MW'(1);
            r_x <= '0;
            r_i <= '0;
        end else if (i_cmd.step) begin
            r_t      <= n_t;
            r_x[r_i] <= r_t[0];
            r_i      <= r_i + IW'(1);
        end
        if (i_cmd.emit) begin
            r_res <= o_sts.eligible ? r_x : '0;
        end
    end

    assign o_inverse = r_res;
    assign o_found   = r_found;

    a_step_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> o_sts.eligible)
        else $error("step issued for a value with no inverse");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_i == '0) && (r_t == MW'(1)))
        else $error("load did not reset the iteration");

endmodule

`default_nettype wire

// ===== rtl/mip_ctrl.sv =====
// ----------------------------------------------------------------------------
// mip_ctrl
// Controller: sequences load, per-bit steps and result emission, and drives
// the busy and valid strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire mip_pkg::t_dp_sts  i_sts,
    output      mip_pkg::t_dp_cmd  o_cmd,
    output      logic              busy,
    output      logic              o_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_cmd.load = start;
            ST_CHECK: o_cmd.emit = !i_sts.eligible;
            ST_RUN:   o_cmd.step = 1'b1;
            ST_FIN:   o_cmd.emit = 1'b1;
            default:  o_cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_cmd.emit;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (i_sts.eligible) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_state <= ST_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (i_sts.last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

endmodule

`default_nettype wire
